// ----- hdl/dobf_pkg.sv -----
// Shared types and constants for the drop-oldest byte-budget descriptor queue.
package dobf_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int TAG_W         = 32;
   localparam int SIZE_W        = 20;
   localparam int NEED_W        = SIZE_W + 1;
   localparam int CNT_OUT_W     = 5;
   localparam int ENT_CFG_W     = 5;
   localparam int CSR_DATA_W    = 20;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ENTRIES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BYTES   = 1'b1;

   localparam logic [ENT_CFG_W-1:0]  RESET_MAX_ENTRIES = 5'd16;
   localparam logic [CSR_DATA_W-1:0] RESET_MAX_BYTES   = 20'hFFFFF;

   typedef enum logic [1:0] {
      CMD_PUT  = 2'd0,
      CMD_GET  = 2'd1,
      CMD_DROP = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_TOO_BIG = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_START,
      SQ_DROP,
      SQ_FINISH
   } seq_state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [NEED_W-1:0] a;
      logic [NEED_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      cmd_type           command;
      logic [TAG_W-1:0]  item_tag;
      logic [SIZE_W-1:0] item_size;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [TAG_W-1:0]     out_tag;
      logic [SIZE_W-1:0]    out_size;
      logic [CNT_OUT_W-1:0] dropped_count;
      logic [CNT_OUT_W-1:0] queue_length;
      logic [SIZE_W-1:0]    queue_bytes;
   } rsp_type;

endpackage

// ----- hdl/dobf_ram.sv -----
// Generic single-write, single-read RAM with registered, write-first read.
module dobf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // forward a same-address write so the head slot reads fresh data
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dobf_budget_alu.sv -----
// Shared byte-budget adder: add or floor-at-zero subtract, then compare to budget.
module dobf_budget_alu (
   input  dobf_pkg::alu_req_type              alu_req,
   input  logic [dobf_pkg::SIZE_W-1:0]        limit,
   output logic [dobf_pkg::NEED_W-1:0]        res,
   output logic                               over
);

   logic                          sub;
   logic [dobf_pkg::NEED_W-1:0]   b_eff;
   logic [dobf_pkg::NEED_W:0]     sum;

   always_comb begin
      sub   = (alu_req.op == dobf_pkg::ALU_SUB);
      b_eff = sub ? ~alu_req.b : alu_req.b;
      sum   = {1'b0, alu_req.a} + {1'b0, b_eff} + (dobf_pkg::NEED_W + 1)'(sub);
      // no carry out on subtract means the operand was smaller: floor at zero
      res   = (sub && !sum[dobf_pkg::NEED_W]) ? '0 : sum[dobf_pkg::NEED_W-1:0];
      over  = res > {1'b0, limit};
   end

endmodule

// ----- hdl/drop_oldest_byte_budget_fifo.sv -----
// Top level: descriptor queue with entry limit, byte budget and drop-oldest admission.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_stall   dobf_pkg::req_type  (command, tag, size)
//   rsp      out  rsp_valid / rsp_stall   dobf_pkg::rsp_type  (status, head, counts)
//   csr      in   csr_write_en            csr_index, csr_write_data
//
// Get, drop, no-op and rejected put run the start and finish steps; an admitted put also passes through the drop step.
// The drop loop retires one head per cycle through the shared budget adder and one RAM read port.
// Reset clears the queue pointers, count and byte total; entry storage is not cleared.
// A stalled result holds in the output register; the next command is taken meanwhile
// and waits only at its own finish step until the output register frees up.
module drop_oldest_byte_budget_fifo #(
   parameter int DEPTH = dobf_pkg::DEFAULT_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dobf_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dobf_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_write_en,
   input  logic [dobf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dobf_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ENT_W = dobf_pkg::TAG_W + dobf_pkg::SIZE_W;
   localparam int LIM_W = (CNT_W > dobf_pkg::ENT_CFG_W) ? CNT_W : dobf_pkg::ENT_CFG_W;

   dobf_pkg::seq_state_type state_ff, state_in;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [IDX_W-1:0]              tail_ff, tail_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [dobf_pkg::SIZE_W-1:0]   total_ff, total_in;
   logic [dobf_pkg::NEED_W-1:0]   need_ff, need_in;
   logic                          over_ff, over_in;
   logic [CNT_W-1:0]              dropped_ff, dropped_in;
   dobf_pkg::status_type          status_ff, status_in;
   logic [dobf_pkg::TAG_W-1:0]    otag_ff, otag_in;
   logic [dobf_pkg::SIZE_W-1:0]   osize_ff, osize_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   dobf_pkg::rsp_type             rsp_ff, rsp_in;
   logic [dobf_pkg::ENT_CFG_W-1:0] max_entries_ff;
   logic [dobf_pkg::SIZE_W-1:0]   max_bytes_ff;

   dobf_pkg::cmd_type             cmd_ff;
   logic [dobf_pkg::TAG_W-1:0]    tag_ff;
   logic [dobf_pkg::SIZE_W-1:0]   size_ff;

   logic                          req_accept;
   logic                          out_free;
   logic                          wr_en;
   logic [ENT_W-1:0]              rd_data;
   logic [dobf_pkg::TAG_W-1:0]    head_tag;
   logic [dobf_pkg::SIZE_W-1:0]   head_size;
   logic [LIM_W-1:0]              me_ext, lim, cnt_ext;
   dobf_pkg::alu_req_type         alu_req;
   logic [dobf_pkg::NEED_W-1:0]   alu_res;
   logic                          alu_over;
   logic [IDX_W-1:0]              head_next, tail_next;

   dobf_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data ({tag_ff, size_ff}),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   dobf_budget_alu u_alu (
      .alu_req (alu_req),
      .limit   (max_bytes_ff),
      .res     (alu_res),
      .over    (alu_over)
   );

   assign head_tag  = rd_data[ENT_W-1:dobf_pkg::SIZE_W];
   assign head_size = rd_data[dobf_pkg::SIZE_W-1:0];
   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   assign tail_next = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + IDX_W'(1);

   // entry limit: zero counts as one, anything above the storage depth saturates
   assign me_ext  = LIM_W'(max_entries_ff);
   assign cnt_ext = LIM_W'(count_ff);
   assign lim     = (me_ext == '0) ? LIM_W'(1) :
                    (me_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : me_ext;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == dobf_pkg::SQ_IDLE) ||
                         ((state_ff == dobf_pkg::SQ_FINISH) && out_free));
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      need_in      = need_ff;
      over_in      = over_ff;
      dropped_in   = dropped_ff;
      status_in    = status_ff;
      otag_in      = otag_ff;
      osize_in     = osize_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      alu_req.op   = dobf_pkg::ALU_ADD;
      alu_req.a    = {1'b0, total_ff};
      alu_req.b    = {1'b0, size_ff};

      case (state_ff)
         dobf_pkg::SQ_IDLE: begin
            if (req_accept) begin
               state_in = dobf_pkg::SQ_START;
            end
         end

         dobf_pkg::SQ_START: begin
            dropped_in = '0;
            otag_in    = '0;
            osize_in   = '0;
            status_in  = dobf_pkg::ST_OK;
            state_in   = dobf_pkg::SQ_FINISH;
            case (cmd_ff)
               dobf_pkg::CMD_PUT: begin
                  if (size_ff > max_bytes_ff) begin
                     status_in = dobf_pkg::ST_TOO_BIG;
                  end else begin
                     need_in  = alu_res;
                     over_in  = alu_over;
                     state_in = dobf_pkg::SQ_DROP;
                  end
               end
               dobf_pkg::CMD_GET, dobf_pkg::CMD_DROP: begin
                  if (count_ff == '0) begin
                     status_in = dobf_pkg::ST_EMPTY;
                  end else begin
                     alu_req.op = dobf_pkg::ALU_SUB;
                     alu_req.b  = {1'b0, head_size};
                     total_in   = alu_res[dobf_pkg::SIZE_W-1:0];
                     head_in    = head_next;
                     count_in   = count_ff - CNT_W'(1);
                     if (cmd_ff == dobf_pkg::CMD_GET) begin
                        otag_in  = head_tag;
                        osize_in = head_size;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         dobf_pkg::SQ_DROP: begin
            if ((count_ff != '0) && ((cnt_ext >= lim) || over_ff)) begin
               // drop the head and take its bytes off the pending total
               alu_req.op = dobf_pkg::ALU_SUB;
               alu_req.a  = need_ff;
               alu_req.b  = {1'b0, head_size};
               need_in    = alu_res;
               over_in    = alu_over;
               head_in    = head_next;
               count_in   = count_ff - CNT_W'(1);
               dropped_in = dropped_ff + CNT_W'(1);
            end else begin
               wr_en    = 1'b1;
               tail_in  = tail_next;
               count_in = count_ff + CNT_W'(1);
               total_in = need_ff[dobf_pkg::SIZE_W-1:0];
               state_in = dobf_pkg::SQ_FINISH;
            end
         end

         dobf_pkg::SQ_FINISH: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.out_tag       = otag_ff;
               rsp_in.out_size      = osize_ff;
               rsp_in.dropped_count = dobf_pkg::CNT_OUT_W'(dropped_ff);
               rsp_in.queue_length  = dobf_pkg::CNT_OUT_W'(count_ff);
               rsp_in.queue_bytes   = total_ff;
               state_in = req_accept ? dobf_pkg::SQ_START : dobf_pkg::SQ_IDLE;
            end
         end

         default: begin
            state_in = dobf_pkg::SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dobf_pkg::SQ_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         max_entries_ff <= dobf_pkg::RESET_MAX_ENTRIES;
         max_bytes_ff   <= dobf_pkg::RESET_MAX_BYTES;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               dobf_pkg::CSR_MAX_ENTRIES: max_entries_ff <= csr_write_data[dobf_pkg::ENT_CFG_W-1:0];
               dobf_pkg::CSR_MAX_BYTES:   max_bytes_ff   <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      need_ff    <= need_in;
      over_ff    <= over_in;
      dropped_ff <= dropped_in;
      status_ff  <= status_in;
      otag_ff    <= otag_in;
      osize_ff   <= osize_in;
      rsp_ff     <= rsp_in;
      if (req_accept) begin
         cmd_ff  <= req_payload.command;
         tag_ff  <= req_payload.item_tag;
         size_ff <= req_payload.item_size;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // the byte total catches up only when the drop loop ends
   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && state_ff != dobf_pkg::SQ_DROP) |-> (total_ff == '0))
      else $error("empty queue holds a nonzero byte total");

   a_empty_pointers: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(DEPTH)))
      else $error("entry count beyond storage depth");

   a_put_admitted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dobf_pkg::SQ_FINISH && cmd_ff == dobf_pkg::CMD_PUT &&
       status_ff == dobf_pkg::ST_OK)
      |-> (count_ff != '0 && cnt_ext <= lim && total_ff <= max_bytes_ff))
      else $error("admitted put leaves queue over its limits");

endmodule
